// File: rtl/core/pbrd_pkg.sv
`timescale 1ns / 1ps
// Package for the pulse beat rate detector: types, register indexes and constants.
// Used by the interfaces, the rate unit and the top level; depends on nothing.
package pbrd_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TIME_W     = 32;
   localparam int BEAT_W     = 11;
   localparam int RATE_W     = 16;
   localparam int SCALE_W    = 20;
   localparam int BIT_IDX_W  = 4;

   localparam logic [CSR_ADDR_W-1:0] REG_SETTLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_RISE   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PEAKS  = 2'd3;

   localparam logic [9:0]  SETTLE_RESET = 10'd200;
   localparam logic [15:0] WINDOW_RESET = 16'd1000;
   localparam logic [6:0]  RISE_RESET   = 7'd2;
   localparam logic [6:0]  PEAKS_RESET  = 7'd16;
   localparam logic [6:0]  SEEN_MAX     = 7'd127;

   localparam int INIT_THRESHOLD = 530;

   localparam logic signed [7:0] RISE_MAX = 8'sh7F;
   localparam logic signed [7:0] RISE_MIN = 8'sh80;

   localparam logic [BEAT_W-1:0]    BEAT_MAX   = 11'd2047;
   localparam logic [SCALE_W-1:0]   RATE_SCALE = 20'd960000;
   localparam logic [RATE_W-1:0]    RATE_MAX   = 16'hFFFF;
   localparam logic [BIT_IDX_W-1:0] TOP_BIT    = 4'd15;

   typedef enum logic [1:0] {
      PH_SETTLE,
      PH_PEAKS,
      PH_RUN
   } phase_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_EVAL,
      CS_WAIT,
      CS_EMIT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      RS_IDLE,
      RS_SUM,
      RS_MUL,
      RS_SAT,
      RS_DIV,
      RS_DONE
   } rate_state_type;

   typedef struct packed {
      logic              beat_inc;
      logic              close;
      logic [TIME_W-1:0] duration;
   } rate_cmd_type;

   typedef struct packed {
      logic              done;
      logic              rate_valid;
      logic [RATE_W-1:0] rate;
   } rate_sts_type;

endpackage

// File: rtl/core/pbrd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample, result and register write ports.
// Depends on pbrd_pkg for the fixed field widths.
interface pbrd_req_if #(parameter int SAMPLE_BITS = 10) ();
   logic                        valid;
   logic                        ready;
   logic [SAMPLE_BITS-1:0]      sample;
   logic [pbrd_pkg::TIME_W-1:0] time_ms;
   modport source (output valid, sample, time_ms, input ready);
   modport sink (input valid, sample, time_ms, output ready);
endinterface

interface pbrd_rsp_if #(parameter int SAMPLE_BITS = 10) ();
   logic                        valid;
   logic                        ready;
   logic                        calibrating;
   logic [SAMPLE_BITS-1:0]      threshold;
   logic                        beat;
   logic                        rate_valid;
   logic [pbrd_pkg::RATE_W-1:0] rate_sixteenths;
   modport source (output valid, calibrating, threshold, beat, rate_valid, rate_sixteenths,
                   input ready);
   modport sink (input valid, calibrating, threshold, beat, rate_valid, rate_sixteenths,
                 output ready);
endinterface

interface pbrd_csr_if ();
   logic                            valid;
   logic                            ready;
   logic [pbrd_pkg::CSR_ADDR_W-1:0] addr;
   logic [pbrd_pkg::CSR_DATA_W-1:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

// File: rtl/core/pbrd_rate_unit.sv
`timescale 1ns / 1ps
// Slot ring of beat counts and durations, with a serial sum, multiply and divide.
// Depends on pbrd_pkg for the command and status structs and the rate constants.
module pbrd_rate_unit #(
   parameter int SLOTS = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pbrd_pkg::rate_cmd_type cmd,
   output pbrd_pkg::rate_sts_type sts
);

   localparam int PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NB_W   = pbrd_pkg::BEAT_W + $clog2(SLOTS);
   localparam int MS_W   = pbrd_pkg::TIME_W + $clog2(SLOTS);
   localparam int PROD_W = NB_W + pbrd_pkg::SCALE_W;
   localparam int DIV_W  = MS_W + pbrd_pkg::RATE_W;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(SLOTS - 1);

   logic [pbrd_pkg::BEAT_W-1:0] beats_ff [SLOTS];
   logic [pbrd_pkg::TIME_W-1:0] millis_ff [SLOTS];

   pbrd_pkg::rate_state_type state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] k_ff, k_in;
   logic [NB_W-1:0]  nb_ff, nb_in;
   logic [MS_W-1:0]  ms_ff, ms_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsh_ff, dsh_in;
   logic [pbrd_pkg::BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [pbrd_pkg::RATE_W-1:0] q_ff, q_in;
   logic rv_ff, rv_in;

   logic [PTR_W-1:0]  rd_addr;
   logic [PTR_W-1:0]  nxt_ptr;
   logic [PROD_W-1:0] prod;
   logic [pbrd_pkg::BEAT_W-1:0] rd_beats;
   logic [pbrd_pkg::TIME_W-1:0] rd_millis;

   logic                        beats_we, millis_we;
   logic [PTR_W-1:0]            beats_wa, millis_wa;
   logic [pbrd_pkg::BEAT_W-1:0] beats_wd;
   logic [pbrd_pkg::TIME_W-1:0] millis_wd;

   assign rd_addr   = (state_ff == pbrd_pkg::RS_SUM) ? k_ff : ptr_ff;
   assign rd_beats  = beats_ff[rd_addr];
   assign rd_millis = millis_ff[rd_addr];
   assign nxt_ptr   = (ptr_ff == LAST) ? '0 : ptr_ff + PTR_W'(1);
   assign prod      = PROD_W'(nb_ff) * PROD_W'(pbrd_pkg::RATE_SCALE);

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      k_in      = k_ff;
      nb_in     = nb_ff;
      ms_in     = ms_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      bit_in    = bit_ff;
      q_in      = q_ff;
      rv_in     = rv_ff;
      beats_we  = 1'b0;
      beats_wa  = ptr_ff;
      beats_wd  = rd_beats;
      millis_we = 1'b0;
      millis_wa = ptr_ff;
      millis_wd = cmd.duration;
      unique case (state_ff)
         pbrd_pkg::RS_IDLE: begin
            if (cmd.beat_inc && (rd_beats < pbrd_pkg::BEAT_MAX)) begin
               beats_we = 1'b1;
               beats_wd = rd_beats + pbrd_pkg::BEAT_W'(1);
            end
            if (cmd.close) begin
               millis_we = 1'b1;
               k_in      = '0;
               nb_in     = '0;
               ms_in     = '0;
               state_in  = pbrd_pkg::RS_SUM;
            end
         end
         pbrd_pkg::RS_SUM: begin
            nb_in = nb_ff + NB_W'(rd_beats);
            ms_in = ms_ff + MS_W'(rd_millis);
            k_in  = k_ff + PTR_W'(1);
            if (k_ff == LAST) begin
               state_in = pbrd_pkg::RS_MUL;
            end
         end
         pbrd_pkg::RS_MUL: begin
            if (ms_ff == '0) begin
               rv_in    = 1'b0;
               q_in     = '0;
               state_in = pbrd_pkg::RS_DONE;
            end else begin
               rem_in   = DIV_W'(prod);
               dsh_in   = {ms_ff, {pbrd_pkg::RATE_W{1'b0}}};
               state_in = pbrd_pkg::RS_SAT;
            end
         end
         pbrd_pkg::RS_SAT: begin
            rv_in = 1'b1;
            if (rem_ff >= dsh_ff) begin
               q_in     = pbrd_pkg::RATE_MAX;
               state_in = pbrd_pkg::RS_DONE;
            end else begin
               q_in     = '0;
               dsh_in   = dsh_ff >> 1;
               bit_in   = pbrd_pkg::TOP_BIT;
               state_in = pbrd_pkg::RS_DIV;
            end
         end
         pbrd_pkg::RS_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in       = rem_ff - dsh_ff;
               q_in[bit_ff] = 1'b1;
            end
            dsh_in = dsh_ff >> 1;
            bit_in = bit_ff - pbrd_pkg::BIT_IDX_W'(1);
            if (bit_ff == '0) begin
               state_in = pbrd_pkg::RS_DONE;
            end
         end
         pbrd_pkg::RS_DONE: begin
            ptr_in    = nxt_ptr;
            beats_we  = 1'b1;
            beats_wa  = nxt_ptr;
            beats_wd  = '0;
            millis_we = 1'b1;
            millis_wa = nxt_ptr;
            millis_wd = '0;
            state_in  = pbrd_pkg::RS_IDLE;
         end
         default: begin
            state_in = pbrd_pkg::RS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbrd_pkg::RS_IDLE;
         ptr_ff   <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            beats_ff[i]  <= '0;
            millis_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         if (beats_we) begin
            beats_ff[beats_wa] <= beats_wd;
         end
         if (millis_we) begin
            millis_ff[millis_wa] <= millis_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      nb_ff  <= nb_in;
      ms_ff  <= ms_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      bit_ff <= bit_in;
      q_ff   <= q_in;
      rv_ff  <= rv_in;
   end

   assign sts.done       = (state_ff == pbrd_pkg::RS_DONE);
   assign sts.rate_valid = rv_ff;
   assign sts.rate       = q_ff;

endmodule

// File: rtl/core/pulse_beat_rate_detector.sv
`timescale 1ns / 1ps
// Pulse beat rate detector. An item passes through accept, evaluate and output load
// when no rate window closes; a sample that closes a window also waits for the slot sum
// over the ring and the serial divider that yields one quotient bit per cycle. The
// block takes no new item until the current one is in the output register; zero
// samples are dropped in the evaluate step with no result. Register writes are taken
// at any time and belong in idle periods.
// Depends on pbrd_pkg, the channel interfaces and pbrd_rate_unit.
module pulse_beat_rate_detector #(
   parameter int SLOTS       = 3,
   parameter int SAMPLE_BITS = 10
) (
   input logic         clock,
   input logic         reset,
   pbrd_req_if.sink    req_chan,
   pbrd_rsp_if.source  rsp_chan,
   pbrd_csr_if.sink    csr_chan
);

   localparam int SB = SAMPLE_BITS;
   localparam logic [SB-1:0] THR_RESET = SB'(pbrd_pkg::INIT_THRESHOLD);

   pbrd_pkg::ctrl_state_type state_ff, state_in;
   pbrd_pkg::phase_type      phase_ff, phase_in;

   logic [9:0]  cfg_settle_ff;
   logic [15:0] cfg_window_ff;
   logic [6:0]  cfg_rise_ff;
   logic [6:0]  cfg_peaks_ff;

   logic [9:0]        settle_count_ff, settle_count_in;
   logic [SB-1:0]     prev_ff, prev_in;
   logic signed [7:0] rise_ff, rise_in;
   logic [6:0]        peaks_seen_ff, peaks_seen_in;
   logic [SB-1:0]     peak_low_ff, peak_low_in;
   logic [SB-1:0]     peak_high_ff, peak_high_in;
   logic [SB-1:0]     thr_ff, thr_in;
   logic              above_ff, above_in;
   logic [15:0]       window_count_ff, window_count_in;
   logic [pbrd_pkg::TIME_W-1:0] window_start_ff, window_start_in;

   logic [SB-1:0]               s_ff, s_in;
   logic [pbrd_pkg::TIME_W-1:0] t_ff, t_in;

   logic                        res_cal_ff, res_cal_in;
   logic [SB-1:0]               res_thr_ff, res_thr_in;
   logic                        res_beat_ff, res_beat_in;
   logic                        res_rv_ff, res_rv_in;
   logic [pbrd_pkg::RATE_W-1:0] res_rate_ff, res_rate_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_cal_ff, out_cal_in;
   logic [SB-1:0]               out_thr_ff, out_thr_in;
   logic                        out_beat_ff, out_beat_in;
   logic                        out_rv_ff, out_rv_in;
   logic [pbrd_pkg::RATE_W-1:0] out_rate_ff, out_rate_in;

   logic          go_peaks;
   logic          ended;
   logic          beat;
   logic          close;
   logic [SB-1:0] low_n, high_n;
   logic [SB:0]   mid_sum;
   logic [6:0]    seen_n;
   logic [15:0]   wc_n;

   pbrd_pkg::rate_cmd_type rate_cmd;
   pbrd_pkg::rate_sts_type rate_sts;

   pbrd_rate_unit #(.SLOTS(SLOTS)) u_rate (
      .clock (clock),
      .reset (reset),
      .cmd   (rate_cmd),
      .sts   (rate_sts)
   );

   assign req_chan.ready = (state_ff == pbrd_pkg::CS_IDLE);
   assign csr_chan.ready = 1'b1;

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      settle_count_in = settle_count_ff;
      prev_in         = prev_ff;
      rise_in         = rise_ff;
      peaks_seen_in   = peaks_seen_ff;
      peak_low_in     = peak_low_ff;
      peak_high_in    = peak_high_ff;
      thr_in          = thr_ff;
      above_in        = above_ff;
      window_count_in = window_count_ff;
      window_start_in = window_start_ff;
      s_in            = s_ff;
      t_in            = t_ff;
      res_cal_in      = res_cal_ff;
      res_thr_in      = res_thr_ff;
      res_beat_in     = res_beat_ff;
      res_rv_in       = res_rv_ff;
      res_rate_in     = res_rate_ff;
      out_cal_in      = out_cal_ff;
      out_thr_in      = out_thr_ff;
      out_beat_in     = out_beat_ff;
      out_rv_in       = out_rv_ff;
      out_rate_in     = out_rate_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      go_peaks        = 1'b0;
      ended           = 1'b0;
      beat            = 1'b0;
      close           = 1'b0;
      low_n           = peak_low_ff;
      high_n          = peak_high_ff;
      mid_sum         = '0;
      seen_n          = peaks_seen_ff;
      wc_n            = window_count_ff + 16'd1;
      rate_cmd        = '0;
      rate_cmd.duration = t_ff - window_start_ff;

      unique case (state_ff)
         pbrd_pkg::CS_IDLE: begin
            if (req_chan.valid) begin
               s_in     = req_chan.sample;
               t_in     = req_chan.time_ms;
               state_in = pbrd_pkg::CS_EVAL;
            end
         end
         pbrd_pkg::CS_EVAL: begin
            if (s_ff == '0) begin
               state_in = pbrd_pkg::CS_IDLE;
            end else begin
               if (phase_ff == pbrd_pkg::PH_SETTLE) begin
                  if (settle_count_ff < cfg_settle_ff) begin
                     prev_in         = s_ff;
                     settle_count_in = settle_count_ff + 10'd1;
                  end else begin
                     phase_in = pbrd_pkg::PH_PEAKS;
                     go_peaks = 1'b1;
                  end
               end
               if (phase_ff == pbrd_pkg::PH_PEAKS) begin
                  go_peaks = 1'b1;
               end

               if (go_peaks) begin
                  if ((s_ff < prev_ff) && (rise_ff > $signed({1'b0, cfg_rise_ff}))) begin
                     low_n        = (s_ff < peak_low_ff) ? s_ff : peak_low_ff;
                     high_n       = (s_ff > peak_high_ff) ? s_ff : peak_high_ff;
                     seen_n       = (peaks_seen_ff < pbrd_pkg::SEEN_MAX) ?
                                    peaks_seen_ff + 7'd1 : peaks_seen_ff;
                     peak_low_in  = low_n;
                     peak_high_in = high_n;
                     peaks_seen_in = seen_n;
                     if (seen_n >= cfg_peaks_ff) begin
                        mid_sum         = {1'b0, low_n} + {1'b0, high_n};
                        thr_in          = mid_sum[SB:1];
                        phase_in        = pbrd_pkg::PH_RUN;
                        window_start_in = t_ff;
                        ended           = 1'b1;
                     end
                  end
                  if (!ended) begin
                     prev_in = s_ff;
                     if (s_ff > prev_ff) begin
                        if (rise_ff < 8'sd0) begin
                           rise_in = 8'sd1;
                        end else if (rise_ff < pbrd_pkg::RISE_MAX) begin
                           rise_in = rise_ff + 8'sd1;
                        end
                     end else begin
                        if (rise_ff > 8'sd0) begin
                           rise_in = -8'sd1;
                        end else if (rise_ff > pbrd_pkg::RISE_MIN) begin
                           rise_in = rise_ff - 8'sd1;
                        end
                     end
                  end
               end else if (phase_ff == pbrd_pkg::PH_RUN) begin
                  beat     = (s_ff <= thr_ff) && above_ff;
                  above_in = (s_ff >= thr_ff);
                  close    = (wc_n >= cfg_window_ff);
                  if (close) begin
                     window_count_in = '0;
                     window_start_in = t_ff;
                  end else begin
                     window_count_in = wc_n;
                  end
                  rate_cmd.beat_inc = beat;
                  rate_cmd.close    = close;
               end

               res_cal_in  = (phase_in != pbrd_pkg::PH_RUN);
               res_thr_in  = thr_in;
               res_beat_in = beat;
               res_rv_in   = 1'b0;
               res_rate_in = '0;
               state_in    = close ? pbrd_pkg::CS_WAIT : pbrd_pkg::CS_EMIT;
            end
         end
         pbrd_pkg::CS_WAIT: begin
            if (rate_sts.done) begin
               res_rv_in   = rate_sts.rate_valid;
               res_rate_in = rate_sts.rate;
               state_in    = pbrd_pkg::CS_EMIT;
            end
         end
         pbrd_pkg::CS_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_cal_in   = res_cal_ff;
               out_thr_in   = res_thr_ff;
               out_beat_in  = res_beat_ff;
               out_rv_in    = res_rv_ff;
               out_rate_in  = res_rate_ff;
               rsp_valid_in = 1'b1;
               state_in     = pbrd_pkg::CS_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pbrd_pkg::CS_IDLE;
         phase_ff        <= pbrd_pkg::PH_SETTLE;
         settle_count_ff <= '0;
         prev_ff         <= '0;
         rise_ff         <= '0;
         peaks_seen_ff   <= '0;
         peak_low_ff     <= '1;
         peak_high_ff    <= '0;
         thr_ff          <= THR_RESET;
         above_ff        <= 1'b0;
         window_count_ff <= '0;
         window_start_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         settle_count_ff <= settle_count_in;
         prev_ff         <= prev_in;
         rise_ff         <= rise_in;
         peaks_seen_ff   <= peaks_seen_in;
         peak_low_ff     <= peak_low_in;
         peak_high_ff    <= peak_high_in;
         thr_ff          <= thr_in;
         above_ff        <= above_in;
         window_count_ff <= window_count_in;
         window_start_ff <= window_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_settle_ff <= pbrd_pkg::SETTLE_RESET;
         cfg_window_ff <= pbrd_pkg::WINDOW_RESET;
         cfg_rise_ff   <= pbrd_pkg::RISE_RESET;
         cfg_peaks_ff  <= pbrd_pkg::PEAKS_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            pbrd_pkg::REG_SETTLE: cfg_settle_ff <= csr_chan.wdata[9:0];
            pbrd_pkg::REG_WINDOW: cfg_window_ff <= csr_chan.wdata;
            pbrd_pkg::REG_RISE:   cfg_rise_ff   <= csr_chan.wdata[6:0];
            pbrd_pkg::REG_PEAKS:  cfg_peaks_ff  <= csr_chan.wdata[6:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      t_ff        <= t_in;
      res_cal_ff  <= res_cal_in;
      res_thr_ff  <= res_thr_in;
      res_beat_ff <= res_beat_in;
      res_rv_ff   <= res_rv_in;
      res_rate_ff <= res_rate_in;
      out_cal_ff  <= out_cal_in;
      out_thr_ff  <= out_thr_in;
      out_beat_ff <= out_beat_in;
      out_rv_ff   <= out_rv_in;
      out_rate_ff <= out_rate_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.calibrating     = out_cal_ff;
   assign rsp_chan.threshold       = out_thr_ff;
   assign rsp_chan.beat            = out_beat_ff;
   assign rsp_chan.rate_valid      = out_rv_ff;
   assign rsp_chan.rate_sixteenths = out_rate_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for pulse_beat_rate_detector: a queue-fed driver, a response
// checker and a beat/rate predictor kept in step with every accepted sample.
// Depends on pbrd_pkg, the channel interfaces in pbrd_if.sv and the detector RTL.
module tb_top;

   localparam int RING      = 3;
   localparam int SMP_W     = 10;
   localparam int HOLD_LEN  = 300;
   localparam int QUIET_GAP = 40;

   typedef struct {
      logic [SMP_W-1:0]            smp;
      logic [pbrd_pkg::TIME_W-1:0] stamp;
   } reading_type;

   typedef struct packed {
      logic                        calibrating;
      logic [SMP_W-1:0]            threshold;
      logic                        beat;
      logic                        rate_valid;
      logic [pbrd_pkg::RATE_W-1:0] rate;
   } beat_report_type;

   logic clock;
   logic reset;
   logic [31:0] cycle_no;
   logic calm;
   logic hold_wanted;
   logic hold_done;
   logic holding;
   int hold_count;
   int error_count;
   logic [pbrd_pkg::TIME_W-1:0] clock_ms;

   reading_type pending_readings[$];
   beat_report_type expected_reports[$];

   logic [9:0]  cfg_settle;
   logic [15:0] cfg_window;
   logic [6:0]  cfg_rise;
   logic [6:0]  cfg_peaks;

   pbrd_pkg::phase_type         det_phase;
   logic [9:0]                  settle_seen;
   logic [SMP_W-1:0]            last_smp;
   logic signed [7:0]           slope_run;
   logic [6:0]                  peaks_found;
   logic [SMP_W-1:0]            peak_min;
   logic [SMP_W-1:0]            peak_max;
   logic [SMP_W-1:0]            beat_level;
   logic                        was_above;
   logic [pbrd_pkg::BEAT_W-1:0] ring_beats[RING];
   logic [pbrd_pkg::TIME_W-1:0] ring_ms[RING];
   int                          ring_slot;
   logic [15:0]                 window_fill;
   logic [pbrd_pkg::TIME_W-1:0] window_origin;

   pbrd_req_if #(.SAMPLE_BITS(SMP_W)) req_if ();
   pbrd_rsp_if #(.SAMPLE_BITS(SMP_W)) rsp_if ();
   pbrd_csr_if csr_if ();

   pulse_beat_rate_detector #(
      .SLOTS(RING),
      .SAMPLE_BITS(SMP_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_top: errors");
      $finish;
   end

   assign calm = (cycle_no % 5000) >= 3500;
   assign holding = hold_wanted && !hold_done;

   always @(posedge clock) begin
      if (reset) begin
         cycle_no <= 0;
         hold_count <= 0;
         hold_done <= 1'b0;
      end else begin
         cycle_no <= cycle_no + 1;
         if (holding) begin
            if (hold_count == HOLD_LEN) begin
               hold_done <= 1'b1;
            end else begin
               hold_count <= hold_count + 1;
            end
         end
      end
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      error_count++;
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic advance_detector(input logic [SMP_W-1:0] smp,
                                   input logic [pbrd_pkg::TIME_W-1:0] stamp);
      beat_report_type res;
      logic ended;
      logic [63:0] beats_sum;
      logic [63:0] ms_sum;
      logic [63:0] quot;
      if (smp == '0) return;
      res = '0;
      ended = 1'b0;
      if (det_phase == pbrd_pkg::PH_SETTLE) begin
         if (settle_seen < cfg_settle) begin
            last_smp = smp;
            settle_seen++;
         end else begin
            det_phase = pbrd_pkg::PH_PEAKS;
         end
      end
      if (det_phase == pbrd_pkg::PH_PEAKS) begin
         if (smp < last_smp && slope_run > $signed({1'b0, cfg_rise})) begin
            if (smp < peak_min) peak_min = smp;
            if (smp > peak_max) peak_max = smp;
            if (peaks_found < pbrd_pkg::SEEN_MAX) peaks_found++;
            if (peaks_found >= cfg_peaks) begin
               beat_level = SMP_W'((11'(peak_min) + 11'(peak_max)) >> 1);
               det_phase = pbrd_pkg::PH_RUN;
               window_origin = stamp;
               ended = 1'b1;
            end
         end
         if (!ended) begin
            if (smp > last_smp) begin
               if (slope_run < 0) slope_run = 8'sd1;
               else if (slope_run < pbrd_pkg::RISE_MAX) slope_run++;
            end else begin
               if (slope_run > 0) slope_run = -8'sd1;
               else if (slope_run > pbrd_pkg::RISE_MIN) slope_run--;
            end
            last_smp = smp;
         end
      end else if (det_phase == pbrd_pkg::PH_RUN) begin
         if (smp <= beat_level && was_above) begin
            res.beat = 1'b1;
            if (ring_beats[ring_slot] < pbrd_pkg::BEAT_MAX) ring_beats[ring_slot]++;
         end
         was_above = (smp >= beat_level);
         window_fill = window_fill + 16'd1;
         if (window_fill >= cfg_window) begin
            window_fill = '0;
            ring_ms[ring_slot] = stamp - window_origin;
            window_origin = stamp;
            beats_sum = '0;
            ms_sum = '0;
            for (int k = 0; k < RING; k++) begin
               beats_sum += 64'(ring_beats[k]);
               ms_sum += 64'(ring_ms[k]);
            end
            if (ms_sum != 0) begin
               quot = beats_sum * 64'(pbrd_pkg::RATE_SCALE) / ms_sum;
               res.rate_valid = 1'b1;
               res.rate = (quot > 64'(pbrd_pkg::RATE_MAX)) ?
                          pbrd_pkg::RATE_MAX : quot[pbrd_pkg::RATE_W-1:0];
            end
            ring_slot = (ring_slot + 1) % RING;
            ring_beats[ring_slot] = '0;
            ring_ms[ring_slot] = '0;
         end
      end
      res.calibrating = (det_phase != pbrd_pkg::PH_RUN);
      res.threshold = beat_level;
      expected_reports.push_back(res);
   endtask

   always @(posedge clock) begin : sample_driver
      reading_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.sample <= '0;
         req_if.time_ms <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            advance_detector(req_if.sample, req_if.time_ms);
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_readings.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
               nxt = pending_readings.pop_front();
               req_if.valid <= 1'b1;
               req_if.sample <= nxt.smp;
               req_if.time_ms <= nxt.stamp;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_check
      beat_report_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_reports.size() == 0) begin
               flag_mismatch("result with nothing expected", 0, 0);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_if.calibrating !== want.calibrating)
                  flag_mismatch("calibrating", rsp_if.calibrating, want.calibrating);
               if (rsp_if.threshold !== want.threshold)
                  flag_mismatch("threshold", rsp_if.threshold, want.threshold);
               if (rsp_if.beat !== want.beat)
                  flag_mismatch("beat", rsp_if.beat, want.beat);
               if (rsp_if.rate_valid !== want.rate_valid)
                  flag_mismatch("rate_valid", rsp_if.rate_valid, want.rate_valid);
               if (rsp_if.rate_sixteenths !== want.rate)
                  flag_mismatch("rate_sixteenths", rsp_if.rate_sixteenths, want.rate);
            end
         end
         rsp_if.ready <= !holding && (calm || $urandom_range(99) >= 22);
      end
   end

   task automatic write_reg(input logic [pbrd_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [pbrd_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.addr <= idx;
      csr_if.wdata <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      case (idx)
         pbrd_pkg::REG_SETTLE: cfg_settle = value[9:0];
         pbrd_pkg::REG_WINDOW: cfg_window = value;
         pbrd_pkg::REG_RISE:   cfg_rise = value[6:0];
         pbrd_pkg::REG_PEAKS:  cfg_peaks = value[6:0];
         default: ;
      endcase
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_readings.size() != 0 || req_if.valid || expected_reports.size() != 0);
      repeat (QUIET_GAP) @(posedge clock);
   endtask

   task automatic queue_reading(input int smp, input logic [pbrd_pkg::TIME_W-1:0] stamp);
      reading_type r;
      r.smp = SMP_W'(smp);
      r.stamp = stamp;
      pending_readings.push_back(r);
   endtask

   // Noisy triangle pulses whose period and swing change from one pulse to the next.
   task automatic queue_pulses(input int count, input int step_max, input int noise_pct);
      int span;
      int pos;
      int lo;
      int hi;
      int half;
      int level;
      span = $urandom_range(4, 20);
      pos = 0;
      lo = $urandom_range(1, 400);
      hi = $urandom_range(600, 1023);
      for (int n = 0; n < count; n++) begin
         pos++;
         if (pos >= span) begin
            pos = 0;
            span = $urandom_range(4, 20);
            lo = $urandom_range(1, 400);
            hi = $urandom_range(600, 1023);
         end
         half = span / 2;
         if (pos < half) level = lo + (hi - lo) * pos / half;
         else level = hi - (hi - lo) * (pos - half) / (span - half);
         if ($urandom_range(99) < noise_pct) level = $urandom_range(0, 1023);
         else if ($urandom_range(99) < 5) level = 0;
         clock_ms += $urandom_range(0, step_max);
         queue_reading(level, clock_ms);
      end
   endtask

   initial begin
      int tries;
      csr_if.valid <= 1'b0;
      csr_if.addr <= '0;
      csr_if.wdata <= '0;
      hold_wanted <= 1'b0;
      error_count = 0;
      clock_ms = $urandom;
      cfg_settle = pbrd_pkg::SETTLE_RESET;
      cfg_window = pbrd_pkg::WINDOW_RESET;
      cfg_rise = pbrd_pkg::RISE_RESET;
      cfg_peaks = pbrd_pkg::PEAKS_RESET;
      det_phase = pbrd_pkg::PH_SETTLE;
      settle_seen = '0;
      last_smp = '0;
      slope_run = '0;
      peaks_found = '0;
      peak_min = '1;
      peak_max = '0;
      beat_level = SMP_W'(pbrd_pkg::INIT_THRESHOLD);
      was_above = 1'b0;
      for (int k = 0; k < RING; k++) begin
         ring_beats[k] = '0;
         ring_ms[k] = '0;
      end
      ring_slot = 0;
      window_fill = '0;
      window_origin = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_reg(pbrd_pkg::REG_SETTLE, 16'd1023);
      write_reg(pbrd_pkg::REG_WINDOW, 16'd0);
      write_reg(pbrd_pkg::REG_RISE, 16'd127);
      write_reg(pbrd_pkg::REG_PEAKS, 16'd1);

      // Field extremes while settling, with zero samples that must vanish.
      queue_reading(1023, 32'h0000_0000);
      queue_reading(0, 32'h0000_007B);
      queue_reading(1, 32'hFFFF_FFFF);
      queue_reading(512, 32'h5555_5555);
      queue_reading(0, 32'h0000_0000);
      queue_reading(341, 32'hAAAA_AAAA);
      queue_reading(682, 32'h0000_0001);
      queue_reading(1023, 32'h0000_0002);
      wait_quiet();

      // Settling ends on the next sample; a rise run no peak can beat drives the
      // slope counter into both limits.
      write_reg(pbrd_pkg::REG_SETTLE, 16'd0);
      write_reg(pbrd_pkg::REG_PEAKS, 16'd64);
      for (int n = 0; n < 130; n++) begin
         clock_ms += $urandom_range(5, 15);
         queue_reading(10 + 7 * n, clock_ms);
      end
      for (int n = 0; n < 132; n++) begin
         clock_ms += $urandom_range(5, 15);
         queue_reading(600, clock_ms);
      end
      wait_quiet();

      write_reg(pbrd_pkg::REG_RISE, 16'd0);
      queue_pulses(40, 15, 3);
      wait_quiet();

      // A zero peak count ends calibration at the first qualifying peak.
      write_reg(pbrd_pkg::REG_RISE, 16'd2);
      write_reg(pbrd_pkg::REG_PEAKS, 16'd0);
      tries = 0;
      do begin
         queue_pulses(30, 15, 2);
         wait_quiet();
         tries++;
      end while (det_phase != pbrd_pkg::PH_RUN && tries < 4);

      queue_pulses(20, 15, 5);
      wait_quiet();

      write_reg(pbrd_pkg::REG_WINDOW, 16'd1);
      write_reg(pbrd_pkg::REG_PEAKS, 16'd127);
      write_reg(pbrd_pkg::REG_SETTLE, 16'd512);
      for (int n = 0; n < 8; n++) queue_reading($urandom_range(1, 1023), clock_ms);
      queue_pulses(20, 1, 5);
      wait_quiet();

      for (int p = 0; p < 6; p++) begin
         write_reg(pbrd_pkg::REG_WINDOW, 16'($urandom_range(2, 25)));
         if (p == 2) begin
            @(posedge clock);
            hold_wanted <= 1'b1;
         end
         if (p == 4) clock_ms = 32'hFFFF_FF80;
         queue_pulses(25, $urandom_range(3, 20), 8);
         wait_quiet();
      end

      write_reg(pbrd_pkg::REG_WINDOW, 16'd3);
      queue_pulses(12, 10, 0);
      wait_quiet();

      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
